// ===== sv/kchdd_pkg.sv =====
// Shared types and constants for the key click / hold / double-click detector.
`timescale 1ns / 1ps

package kchdd_pkg;

   localparam int unsigned KeyWidth   = 4;
   localparam int unsigned EventWidth = 8;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrWidth   = 8;

   localparam logic [KeyWidth-1:0]   NoKey       = 4'hf;
   localparam logic [EventWidth-1:0] NoEvent     = 8'h0f;
   localparam logic [CountWidth-1:0] CountMax    = 8'hff;
   localparam logic [CsrWidth-1:0]   LongPressRst = 8'd50;
   localparam logic [CsrWidth-1:0]   WindowRst    = 8'd5;

   // csr register indexes
   localparam logic CsrLongPress = 1'b0;
   localparam logic CsrWindow    = 1'b1;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_PRESSED = 4'b0010,
      MODE_WAITING = 4'b0100,
      MODE_SECOND  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [CountWidth-1:0] long_press_ticks;
      logic [CountWidth-1:0] release_window_ticks;
   } cfg_type;

endpackage

// ===== sv/kchdd_fsm.sv =====
// Press-mode state machine: per-request state update and event decode.
`timescale 1ns / 1ps

module kchdd_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [kchdd_pkg::KeyWidth-1:0]    key_code,
   input  kchdd_pkg::cfg_type                cfg,
   output logic [kchdd_pkg::EventWidth-1:0]  key_event
);

   kchdd_pkg::mode_type                   mode_ff, mode_in;
   logic [kchdd_pkg::CountWidth-1:0]      hold_ff, hold_in;
   logic [kchdd_pkg::KeyWidth-1:0]        saved_ff, saved_in;
   logic [kchdd_pkg::CountWidth-1:0]      rel_ff, rel_in;
   logic [kchdd_pkg::CountWidth-1:0]      rel_inc;

   // saturating release counter
   assign rel_inc = (rel_ff == kchdd_pkg::CountMax) ? rel_ff : rel_ff + 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      hold_in   = hold_ff;
      saved_in  = saved_ff;
      rel_in    = rel_ff;
      key_event = kchdd_pkg::NoEvent;
      if (key_code != kchdd_pkg::NoKey) begin
         case (mode_ff)
            kchdd_pkg::MODE_IDLE: begin
               mode_in  = kchdd_pkg::MODE_PRESSED;
               hold_in  = '0;
               saved_in = key_code;
            end
            kchdd_pkg::MODE_WAITING: begin
               if (saved_ff == key_code) mode_in = kchdd_pkg::MODE_SECOND;
            end
            kchdd_pkg::MODE_SECOND: begin
               mode_in   = kchdd_pkg::MODE_IDLE;
               key_event = {saved_ff[2:0], 5'b0};
            end
            kchdd_pkg::MODE_PRESSED: begin
               if (hold_ff == cfg.long_press_ticks) begin
                  // long hold: reports the key seen now
                  key_event = {key_code, 4'b0};
               end else if (hold_ff == '0) begin
                  if (saved_ff != key_code) begin
                     mode_in = kchdd_pkg::MODE_IDLE;
                     hold_in = '0;
                  end else begin
                     hold_in = 8'd1;
                  end
               end else if (hold_ff < cfg.long_press_ticks) begin
                  hold_in = hold_ff + 1'b1;
               end
            end
            default: begin
               mode_in = kchdd_pkg::MODE_IDLE;
            end
         endcase
      end else begin
         if (mode_ff == kchdd_pkg::MODE_PRESSED && hold_ff < cfg.long_press_ticks) begin
            mode_in = kchdd_pkg::MODE_WAITING;
            hold_in = '0;
            rel_in  = '0;
         end else if (mode_ff == kchdd_pkg::MODE_WAITING) begin
            rel_in = rel_inc;
            if (rel_inc > cfg.release_window_ticks) begin
               mode_in   = kchdd_pkg::MODE_IDLE;
               key_event = {4'b0, saved_ff};
            end
         end else begin
            mode_in = kchdd_pkg::MODE_IDLE;
            hold_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= kchdd_pkg::MODE_IDLE;
         hold_ff  <= '0;
         saved_ff <= kchdd_pkg::NoKey;
         rel_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         hold_ff  <= hold_in;
         saved_ff <= saved_in;
         rel_ff   <= rel_in;
      end
   end

endmodule

// ===== sv/key_click_hold_double_click_detector.sv =====
// Top level of the key click / long-hold / double-click detector.
`timescale 1ns / 1ps

// One sampled key code per request (15 = no key) yields exactly one 8-bit
// event: 15 for nothing, the key for a click, key<<4 on each tick of a long
// hold, and (key<<5)&255 for a double click. The edge that accepts the
// request loads the input register; once the response register is free, a
// later edge runs the mode state machine, updates its state and loads the
// response register. A new request is accepted every cycle while the
// response side takes results; throughput is one request per clock. The
// csr registers (index 0: long-press count, index 1: release window) should
// be written only while no request is in flight.
module key_click_hold_double_click_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [kchdd_pkg::KeyWidth-1:0]     req_key_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kchdd_pkg::EventWidth-1:0]   rsp_key_event,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [kchdd_pkg::CsrWidth-1:0]     csr_write_data
);

   kchdd_pkg::cfg_type                     cfg_ff;
   logic                                   in_valid_ff;
   logic [kchdd_pkg::KeyWidth-1:0]         in_key_ff;
   logic                                   out_valid_ff;
   logic [kchdd_pkg::EventWidth-1:0]       out_event_ff;
   logic [kchdd_pkg::EventWidth-1:0]       event_in;
   logic                                   out_free;
   logic                                   step;

   // response register can take a new result
   assign out_free  = !out_valid_ff || rsp_ready;
   // held request moves into the state machine this cycle
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks     <= kchdd_pkg::LongPressRst;
         cfg_ff.release_window_ticks <= kchdd_pkg::WindowRst;
      end else if (csr_write_enable) begin
         case (csr_index)
            kchdd_pkg::CsrLongPress: cfg_ff.long_press_ticks     <= csr_write_data;
            kchdd_pkg::CsrWindow:    cfg_ff.release_window_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_key_ff <= req_key_code;
   end

   kchdd_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .key_code  (in_key_ff),
      .cfg       (cfg_ff),
      .key_event (event_in)
   );

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) out_event_ff <= event_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = out_event_ff;

endmodule

// ===== verif/tb_key_click_hold_double_click_detector.sv =====
// Testbench for the key click / long-hold / double-click detector.
`timescale 1ns / 1ps

// Stimulus runs in three stages:
//   - a short hand-written key sequence under a tight setting (long press 2,
//     release window 1) that walks the click, long hold, double click and
//     the odd cases: a different key on the first held tick, a different key
//     while waiting on a release, a release during the second press, and a
//     release after a long hold;
//   - a hold that runs on across a csr write that lowers the long-press
//     count below the count already reached;
//   - random phases, each under its own csr setting (the extremes among
//     them), built mostly from well-formed clicks, double clicks and long
//     holds with random keys, mixed with noise.
// A small board class tracks the detector state, predicts one event per
// accepted request and compares it with the oldest event in its queue.
module tb_key_click_hold_double_click_detector;

   import kchdd_pkg::*;

   // predicted detector state plus the queue of events still to arrive
   class key_event_board;
      logic [CountWidth-1:0] long_press_ticks;
      logic [CountWidth-1:0] release_window_ticks;
      mode_type              mode;
      logic [CountWidth-1:0] hold_count;
      logic [KeyWidth-1:0]   saved_key;
      logic [CountWidth-1:0] release_ticks;
      logic [EventWidth-1:0] queued_events[$];
      int                    fail_count;

      function new();
         long_press_ticks     = LongPressRst;
         release_window_ticks = WindowRst;
         mode                 = MODE_IDLE;
         hold_count           = '0;
         saved_key            = NoKey;
         release_ticks        = '0;
         fail_count           = 0;
      endfunction

      function void set_register(logic idx, logic [CsrWidth-1:0] value);
         if (idx == CsrLongPress) begin
            long_press_ticks = value;
         end else begin
            release_window_ticks = value;
         end
      endfunction

      // advance the state by one scan tick and queue the event it gives
      function void take_key(logic [KeyWidth-1:0] key);
         logic [EventWidth-1:0] ev;
         ev = NoEvent;
         if (key != NoKey) begin
            case (mode)
               MODE_IDLE: begin
                  mode       = MODE_PRESSED;
                  hold_count = '0;
                  saved_key  = key;
               end
               MODE_WAITING: begin
                  // other keys are ignored while waiting
                  if (saved_key == key) mode = MODE_SECOND;
               end
               MODE_SECOND: begin
                  mode = MODE_IDLE;
                  ev   = {saved_key[2:0], 5'b0};
               end
               default: begin
                  if (hold_count == long_press_ticks) begin
                     ev = {key, 4'b0};
                  end else if (hold_count == '0) begin
                     if (saved_key != key) begin
                        mode       = MODE_IDLE;
                        hold_count = '0;
                     end else begin
                        hold_count = 8'd1;
                     end
                  end else if (hold_count < long_press_ticks) begin
                     hold_count = hold_count + 8'd1;
                  end
               end
            endcase
         end else begin
            if (mode == MODE_PRESSED && hold_count < long_press_ticks) begin
               mode          = MODE_WAITING;
               hold_count    = '0;
               release_ticks = '0;
            end else if (mode == MODE_WAITING) begin
               if (release_ticks != CountMax) release_ticks = release_ticks + 8'd1;
               if (release_ticks > release_window_ticks) begin
                  mode = MODE_IDLE;
                  ev   = {4'b0, saved_key};
               end
            end else begin
               mode       = MODE_IDLE;
               hold_count = '0;
            end
         end
         queued_events.push_back(ev);
      endfunction

      function void match_event(logic [EventWidth-1:0] actual);
         logic [EventWidth-1:0] want;
         if (queued_events.size() == 0) begin
            $error("key_event: unexpected response, actual %0d", actual);
            fail_count++;
            return;
         end
         want = queued_events.pop_front();
         if (actual !== want) begin
            $error("key_event mismatch: expected %0d, actual %0d", want, actual);
            fail_count++;
         end
      endfunction

      function int pending();
         return queued_events.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KeyWidth-1:0]   req_key_code;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [EventWidth-1:0] rsp_key_event;
   logic                  csr_write_enable;
   logic                  csr_index;
   logic [CsrWidth-1:0]   csr_write_data;

   key_event_board board = new();
   bit             no_idle;   // set for stretches where the sender never pauses

   key_click_hold_double_click_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_event    (rsp_key_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side stalls: runs of ready, sometimes very long, then a gap
   initial begin
      int hi_len;
      int lo_len;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (hi_len) @(posedge clock);
         lo_len = pick_gap();
         if (lo_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (lo_len) @(posedge clock);
         end
      end
   end

   // every response accepted at an edge is checked against the queue
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.match_event(rsp_key_event);
   end

   // one request; valid stays high across back-to-back requests
   task automatic send_key(logic [KeyWidth-1:0] key);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (!req_ready);
      board.take_key(key);
   endtask

   task automatic send_run(logic [KeyWidth-1:0] key, int count);
      repeat (count) send_key(key);
   endtask

   // sender drops valid and waits until every expected event is back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CsrWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_register(idx, value);
   endtask

   // hold length that still releases below a nonzero long-press count
   function automatic int short_press();
      int lp;
      lp = board.long_press_ticks;
      if (lp == 0) return 1;
      if ($urandom_range(0, 9) == 0) return lp;   // released one tick short
      return $urandom_range(1, (lp < 6) ? lp : 6);
   endfunction

   // one random key gesture under the current setting
   task automatic play_gesture(ref int used);
      int                  kind;
      int                  n;
      int                  q;
      int                  win;
      logic [KeyWidth-1:0] key;
      logic [KeyWidth-1:0] other;
      kind    = $urandom_range(0, 99);
      key     = 4'($urandom_range(0, 14));
      other   = key ^ 4'($urandom_range(1, 15));
      win     = board.release_window_ticks;
      no_idle = ($urandom_range(0, 3) == 0);
      if (kind < 30) begin
         // click: press, release, quiet around the end of the window
         n = short_press();
         send_run(key, n);
         if ($urandom_range(0, 9) == 0) begin
            send_key(NoKey);
            send_key(other);          // stray key while waiting
            n += 2;
         end
         q = win + 1 + $urandom_range(0, 2);
         send_run(NoKey, q);
         used += n + q;
      end else if (kind < 60) begin
         // double click: second press inside the window
         n = short_press();
         send_run(key, n);
         q = ($urandom_range(0, 4) == 0) ? win + 1
                                         : $urandom_range(1, (win < 7) ? win + 1 : 8);
         send_run(NoKey, q);
         send_key(key);
         case ($urandom_range(0, 6))
            0:       send_key(NoKey);   // release during the second press
            1:       send_key(other);
            default: send_key(key);
         endcase
         used += n + q + 2;
      end else if (kind < 80) begin
         // long hold, then release
         n = board.long_press_ticks + 1 + $urandom_range(0, 4);
         send_run(key, n);
         q = $urandom_range(1, 3);
         send_run(NoKey, q);
         used += n + q;
      end else begin
         // noise
         n = $urandom_range(1, 8);
         repeat (n) begin
            send_key(($urandom_range(0, 9) < 4) ? NoKey : 4'($urandom_range(0, 15)));
         end
         used += n;
      end
   endtask

   initial begin
      // long press 2, release window 1 for the walk-through
      logic [KeyWidth-1:0] walk[] = '{
         4'h0, 4'h0, NoKey, NoKey, NoKey,   // click on key 0
         4'he, 4'he, 4'he, 4'he, NoKey,     // long hold on key 14, release
         4'h7, NoKey, 4'h7, 4'h7,           // double click on key 7
         4'h3, NoKey, 4'h3, NoKey,          // release during second press
         4'h5, 4'h6,                        // different key on first held tick
         4'h9, NoKey, 4'h4, NoKey, NoKey    // stray key while waiting, click on 9
      };
      logic [CsrWidth-1:0] long_set[] = '{8'd50, 8'd0, 8'd1, 8'd255, 8'd3, 8'd255,
                                          8'd1, 8'd4, 8'd0};
      logic [CsrWidth-1:0] win_set[]  = '{8'd5, 8'd0, 8'd0, 8'd254, 8'd255, 8'd0,
                                          8'd255, 8'd2, 8'd3};
      int phase;
      int used;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_key_code     <= NoKey;
      csr_write_enable <= 1'b0;
      csr_index        <= CsrLongPress;
      csr_write_data   <= '0;
      no_idle          = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CsrLongPress, 8'd2);
      write_csr(CsrWindow, 8'd1);
      foreach (walk[i]) send_key(walk[i]);
      settle();

      // hold past 9 ticks, then drop the long-press count to 3 mid-hold:
      // the count stays above the limit, so no long-hold event follows
      write_csr(CsrLongPress, 8'd20);
      send_run(4'h8, 10);
      settle();
      write_csr(CsrLongPress, 8'd3);
      send_run(4'h8, 3);
      send_key(NoKey);
      settle();

      // random phases: the fixed settings first, then small random ones
      for (phase = 0; phase < 11; phase++) begin
         if (phase < long_set.size()) begin
            write_csr(CsrLongPress, long_set[phase]);
            write_csr(CsrWindow, win_set[phase]);
         end else begin
            write_csr(CsrLongPress, 8'($urandom_range(1, 12)));
            write_csr(CsrWindow, 8'($urandom_range(0, 8)));
         end
         used = 0;
         while (used < 40) play_gesture(used);
         no_idle = 1'b0;
         // an unfinished press now and then carries into the next setting
         if ($urandom_range(0, 1) == 0) send_run(4'($urandom_range(0, 14)),
                                                 $urandom_range(1, 6));
         settle();
      end

      repeat (8) @(posedge clock);
      if (board.fail_count == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (board.pending() != 0) begin
            $error("key_event: %0d expected events never arrived", board.pending());
         end
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
